[rtl/fbds_pkg.sv]
package fbds_pkg;

  // Field widths
  localparam int unsigned ClkW    = 28;
  localparam int unsigned PctW    = 7;
  localparam int unsigned BaudW   = 22;
  localparam int unsigned PortW   = 2;
  localparam int unsigned DivisorW = 16;
  localparam int unsigned FracW   = 4;
  localparam int unsigned ErrW    = 17;

  // Oversampled clock = core clock / 64
  localparam int unsigned ClkShift = 6;
  localparam int unsigned OsClkW   = ClkW - ClkShift;

  // Shared serial divider: numerator covers baud * percent, denominator covers baud
  localparam int unsigned NumW = BaudW + PctW;
  localparam int unsigned DenW = BaudW;
  localparam int unsigned CntW = $clog2(NumW);
  localparam int unsigned TolW = BaudW + 1;

  // Configuration register indexes
  localparam logic CfgIdxCoreClock = 1'b0;
  localparam logic CfgIdxErrPct    = 1'b1;

  localparam logic [ClkW-1:0] CoreClockRst = ClkW'(100000000);
  localparam logic [PctW-1:0] ErrPctRst    = PctW'(3);

  localparam logic [ErrW-1:0]  NoErrorYet = ErrW'(100000);
  localparam logic [DenW-1:0]  PctDen     = DenW'(100);
  localparam logic [FracW-1:0] FracMax    = FracW'(15);
  localparam logic [FracW-1:0] MulFirst   = FracW'(1);
  localparam logic [BaudW:0]   DivMin     = (BaudW+1)'(3);
  localparam logic [BaudW:0]   DivMax     = (BaudW+1)'(65535);

  // Result status codes
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

endpackage

[rtl/fractional_baud_divisor_search.sv]
// Channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------------
// request  | in_valid_i / in_stall_o    | baud_rate_i, target_port_i
// result   | out_valid_o / out_stall_i  | status_o, port_echo_o, divisor_o, mul_val_o,
//          |                            | div_add_val_o, rate_error_o
// config   | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One restoring divider (one quotient bit per cycle) does all the work. Per candidate
// pair: up to three divisions and the bookkeeping states S_SCALED, S_CHK, S_EVAL, S_NEXT.
// After the tolerance division the search tries up to 240 pairs (mul 1..15, add 0..15);
// an exact match ends the search early, and a zero baud rate skips the search.
// in_stall_o is high from acceptance until the result is loaded into the output register.
// A held result does not block the next request; a finished search waits while the
// output register is still full and stalled. Reset clears control, presets config regs.
module fractional_baud_divisor_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [fbds_pkg::ClkW-1:0]        cfg_wdata_i,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fbds_pkg::BaudW-1:0]       baud_rate_i,
  input  logic [fbds_pkg::PortW-1:0]       target_port_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             status_o,
  output logic [fbds_pkg::PortW-1:0]       port_echo_o,
  output logic [fbds_pkg::DivisorW-1:0]    divisor_o,
  output logic [fbds_pkg::FracW-1:0]       mul_val_o,
  output logic [fbds_pkg::FracW-1:0]       div_add_val_o,
  output logic [fbds_pkg::ErrW-1:0]        rate_error_o
);

  localparam int unsigned NumW   = fbds_pkg::NumW;
  localparam int unsigned DenW   = fbds_pkg::DenW;
  localparam int unsigned BaudW  = fbds_pkg::BaudW;
  localparam int unsigned FracW  = fbds_pkg::FracW;
  localparam int unsigned OsClkW = fbds_pkg::OsClkW;
  localparam int unsigned ProdW  = OsClkW + FracW;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TOL    = 4'd1;  // divide: baud * pct / 100
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_SCALE  = 4'd3;  // divide: mul * os_clk / (mul + add)
  localparam logic [3:0] S_SCALED = 4'd4;
  localparam logic [3:0] S_DVD    = 4'd5;  // divide: scaled / baud
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_RATE   = 4'd7;  // divide: scaled / divisor
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_q, state_d;

  // Config registers
  logic [fbds_pkg::ClkW-1:0] core_clk_q;
  logic [fbds_pkg::PctW-1:0] err_pct_q;

  // Request and search registers
  logic [BaudW-1:0]             baud_q, baud_d;
  logic [fbds_pkg::PortW-1:0]   port_q, port_d;
  logic [fbds_pkg::TolW-1:0]    tol_q, tol_d;
  logic [FracW-1:0]             mul_q, mul_d, add_q, add_d;
  logic [OsClkW-1:0]            scaled_q, scaled_d;
  logic [fbds_pkg::DivisorW-1:0] dv_q, dv_d;
  logic [fbds_pkg::ErrW-1:0]    best_err_q, best_err_d;
  logic [FracW-1:0]             best_mul_q, best_mul_d, best_add_q, best_add_d;
  logic [fbds_pkg::DivisorW-1:0] best_div_q, best_div_d;

  // Shared divider: num_q shifts the numerator out and the quotient in
  logic [NumW-1:0]              num_q, num_d;
  logic [DenW-1:0]              den_q, den_d, rem_q, rem_d;
  logic [fbds_pkg::CntW-1:0]    cnt_q, cnt_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic                         status_q, status_d;
  logic [fbds_pkg::PortW-1:0]   port_echo_q, port_echo_d;
  logic [fbds_pkg::DivisorW-1:0] divisor_q, divisor_d;
  logic [FracW-1:0]             mul_out_q, mul_out_d, add_out_q, add_out_d;
  logic [fbds_pkg::ErrW-1:0]    err_out_q, err_out_d;

  logic                         in_acc, out_acc;
  logic [DenW:0]                trial;
  logic                         trial_ge;
  logic                         div_last;
  logic [OsClkW-1:0]            os_clk;
  logic [FracW-1:0]             mul_sel, add_sel;
  logic [ProdW-1:0]             scale_prod;
  logic [FracW:0]               scale_den;
  logic [BaudW:0]               dv_round;
  logic [BaudW-1:0]             rate, err;
  logic                         better;
  logic                         pass;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign os_clk = core_clk_q[fbds_pkg::ClkW-1:fbds_pkg::ClkShift];

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign trial    = {rem_q, num_q[NumW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign div_last = (cnt_q == fbds_pkg::CntW'(NumW - 1));

  // Candidate pair for the next scale division (advance happens in S_NEXT)
  always_comb begin
    mul_sel = mul_q;
    add_sel = add_q;
    if (state_q == S_NEXT) begin
      if (add_q == fbds_pkg::FracMax) begin
        mul_sel = mul_q + FracW'(1);
        add_sel = '0;
      end else begin
        add_sel = add_q + FracW'(1);
      end
    end
  end

  assign scale_prod = ProdW'(mul_sel) * ProdW'(os_clk);
  assign scale_den  = {1'b0, mul_sel} + {1'b0, add_sel};

  // Round to nearest; an exact half rounds down
  assign dv_round = {1'b0, num_q[BaudW-1:0]} +
                    (BaudW+1)'(rem_q > (baud_q >> 1));

  assign rate   = num_q[BaudW-1:0];
  assign err    = (rate <= baud_q) ? (baud_q - rate) : (rate - baud_q);
  assign better = (err < BaudW'(best_err_q));

  assign pass = (baud_q != '0) && (best_mul_q != '0) &&
                (fbds_pkg::TolW'(best_err_q) < tol_q);

  always_comb begin
    state_d     = state_q;
    baud_d      = baud_q;
    port_d      = port_q;
    tol_d       = tol_q;
    mul_d       = mul_q;
    add_d       = add_q;
    scaled_d    = scaled_q;
    dv_d        = dv_q;
    best_err_d  = best_err_q;
    best_mul_d  = best_mul_q;
    best_add_d  = best_add_q;
    best_div_d  = best_div_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_acc;
    status_d    = status_q;
    port_echo_d = port_echo_q;
    divisor_d   = divisor_q;
    mul_out_d   = mul_out_q;
    add_out_d   = add_out_q;
    err_out_d   = err_out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          baud_d     = baud_rate_i;
          port_d     = target_port_i;
          mul_d      = fbds_pkg::MulFirst;
          add_d      = '0;
          best_err_d = fbds_pkg::NoErrorYet;
          best_mul_d = '0;
          best_add_d = '0;
          best_div_d = '0;
          num_d      = NumW'(baud_rate_i) * NumW'(err_pct_q);
          den_d      = fbds_pkg::PctDen;
          rem_d      = '0;
          cnt_d      = '0;
          state_d    = S_TOL;
        end
      end

      S_TOL, S_SCALE, S_DVD, S_RATE: begin
        num_d = {num_q[NumW-2:0], trial_ge};
        rem_d = trial_ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
        cnt_d = cnt_q + fbds_pkg::CntW'(1);
        if (div_last) begin
          unique case (state_q)
            S_TOL:   state_d = S_SETUP;
            S_SCALE: state_d = S_SCALED;
            S_DVD:   state_d = S_CHK;
            default: state_d = S_EVAL;
          endcase
        end
      end

      S_SETUP, S_NEXT: begin
        if (state_q == S_SETUP) begin
          tol_d = num_q[fbds_pkg::TolW-1:0];
        end
        if (baud_q == '0) begin
          state_d = S_FIN;
        end else if (state_q == S_NEXT && add_q == fbds_pkg::FracMax &&
                     mul_q == fbds_pkg::FracMax) begin
          state_d = S_FIN;
        end else begin
          mul_d   = mul_sel;
          add_d   = add_sel;
          num_d   = NumW'(scale_prod);
          den_d   = DenW'(scale_den);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_SCALE;
        end
      end

      S_SCALED: begin
        scaled_d = num_q[OsClkW-1:0];
        num_d    = num_q;
        den_d    = baud_q;
        rem_d    = '0;
        cnt_d    = '0;
        state_d  = S_DVD;
      end

      S_CHK: begin
        if (dv_round < fbds_pkg::DivMin || dv_round > fbds_pkg::DivMax) begin
          state_d = S_NEXT;
        end else begin
          dv_d    = dv_round[fbds_pkg::DivisorW-1:0];
          num_d   = NumW'(scaled_q);
          den_d   = DenW'(dv_round[fbds_pkg::DivisorW-1:0]);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_RATE;
        end
      end

      S_EVAL: begin
        state_d = S_NEXT;
        if (better) begin
          best_err_d = err[fbds_pkg::ErrW-1:0];
          best_mul_d = mul_q;
          best_add_d = add_q;
          best_div_d = dv_q;
          if (err == '0) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        // Wait for the output register to free up
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          port_echo_d = port_q;
          err_out_d   = best_err_q;
          if (pass) begin
            status_d  = fbds_pkg::StatusOk;
            divisor_d = best_div_q;
            mul_out_d = best_mul_q;
            add_out_d = best_add_q;
          end else begin
            status_d  = fbds_pkg::StatusFail;
            divisor_d = '0;
            mul_out_d = '0;
            add_out_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      core_clk_q  <= fbds_pkg::CoreClockRst;
      err_pct_q   <= fbds_pkg::ErrPctRst;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fbds_pkg::CfgIdxCoreClock: core_clk_q <= cfg_wdata_i;
          fbds_pkg::CfgIdxErrPct:    err_pct_q  <= cfg_wdata_i[fbds_pkg::PctW-1:0];
        endcase
      end
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk_i) begin
    baud_q      <= baud_d;
    port_q      <= port_d;
    tol_q       <= tol_d;
    mul_q       <= mul_d;
    add_q       <= add_d;
    scaled_q    <= scaled_d;
    dv_q        <= dv_d;
    best_err_q  <= best_err_d;
    best_mul_q  <= best_mul_d;
    best_add_q  <= best_add_d;
    best_div_q  <= best_div_d;
    num_q       <= num_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    status_q    <= status_d;
    port_echo_q <= port_echo_d;
    divisor_q   <= divisor_d;
    mul_out_q   <= mul_out_d;
    add_out_q   <= add_out_d;
    err_out_q   <= err_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign port_echo_o   = port_echo_q;
  assign divisor_o     = divisor_q;
  assign mul_val_o     = mul_out_q;
  assign div_add_val_o = add_out_q;
  assign rate_error_o  = err_out_q;

endmodule
